### hdl/art_pkg.sv
// Shared types, constants and the multiply-accumulate program of the arcball tracker.
// Used by art_front, art_isqrt, art_back and arcball_rotation_tracker.
`default_nettype none
package art_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int COORD_BITS = 14;
  localparam int CFG_BITS   = COORD_BITS - 1;
  localparam int Q_BITS     = FRAC_BITS + 2;
  localparam int EXTRA_BITS = 15;
  localparam int ROOT_STEPS = 30;
  localparam int MAC_TERMS  = 25;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_DRAG  = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;

  localparam logic [15:0] Q_ONE = 16'd16384;

  localparam logic [3:0] OPD_S0 = 4'd0;
  localparam logic [3:0] OPD_S1 = 4'd1;
  localparam logic [3:0] OPD_S2 = 4'd2;
  localparam logic [3:0] OPD_C0 = 4'd3;
  localparam logic [3:0] OPD_C1 = 4'd4;
  localparam logic [3:0] OPD_C2 = 4'd5;
  localparam logic [3:0] OPD_Q0 = 4'd6;
  localparam logic [3:0] OPD_Q1 = 4'd7;
  localparam logic [3:0] OPD_Q2 = 4'd8;
  localparam logic [3:0] OPD_Q3 = 4'd9;
  localparam logic [3:0] OPD_B0 = 4'd10;
  localparam logic [3:0] OPD_B1 = 4'd11;
  localparam logic [3:0] OPD_B2 = 4'd12;
  localparam logic [3:0] OPD_B3 = 4'd13;

  typedef enum logic [1:0] {CMD_BEGIN, CMD_DRAG, CMD_LOAD, CMD_NOP} cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [13:0] px;
    logic signed [13:0] py;
    logic signed [15:0] lw;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] lz;
  } item_t;

  typedef struct packed {
    logic [12:0] cx;
    logic [12:0] cy;
    logic [12:0] rad;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MAP0, ST_SQX, ST_SQY, ST_SQR, ST_CMP, ST_LEN, ST_DIVS, ST_DIV,
    ST_DIVE, ST_MZX, ST_MZY, ST_MZS, ST_ZSQ, ST_PTS, ST_MUL, ST_ACC, ST_DONE
  } state_e;

  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
    logic       neg;
    logic       first;
    logic       last;
    logic [2:0] dest;
  } mac_t;

  function automatic mac_t mk(input logic [3:0] a, input logic [3:0] b, input logic neg,
                              input logic first, input logic last, input logic [2:0] dest);
    mac_t m;
    m.a = a; m.b = b; m.neg = neg; m.first = first; m.last = last; m.dest = dest;
    return m;
  endfunction

  // dot, cross, then Hamilton product q * base
  function automatic mac_t mac_entry(input logic [4:0] t);
    mac_t m;
    case (t)
      5'd0:  m = mk(OPD_S0, OPD_C0, 1'b0, 1'b1, 1'b0, 3'd0);
      5'd1:  m = mk(OPD_S1, OPD_C1, 1'b0, 1'b0, 1'b0, 3'd0);
      5'd2:  m = mk(OPD_S2, OPD_C2, 1'b0, 1'b0, 1'b1, 3'd0);
      5'd3:  m = mk(OPD_S1, OPD_C2, 1'b0, 1'b1, 1'b0, 3'd1);
      5'd4:  m = mk(OPD_S2, OPD_C1, 1'b1, 1'b0, 1'b1, 3'd1);
      5'd5:  m = mk(OPD_S2, OPD_C0, 1'b0, 1'b1, 1'b0, 3'd2);
      5'd6:  m = mk(OPD_S0, OPD_C2, 1'b1, 1'b0, 1'b1, 3'd2);
      5'd7:  m = mk(OPD_S0, OPD_C1, 1'b0, 1'b1, 1'b0, 3'd3);
      5'd8:  m = mk(OPD_S1, OPD_C0, 1'b1, 1'b0, 1'b1, 3'd3);
      5'd9:  m = mk(OPD_Q0, OPD_B0, 1'b0, 1'b1, 1'b0, 3'd4);
      5'd10: m = mk(OPD_Q1, OPD_B1, 1'b1, 1'b0, 1'b0, 3'd4);
      5'd11: m = mk(OPD_Q2, OPD_B2, 1'b1, 1'b0, 1'b0, 3'd4);
      5'd12: m = mk(OPD_Q3, OPD_B3, 1'b1, 1'b0, 1'b1, 3'd4);
      5'd13: m = mk(OPD_Q0, OPD_B1, 1'b0, 1'b1, 1'b0, 3'd5);
      5'd14: m = mk(OPD_Q1, OPD_B0, 1'b0, 1'b0, 1'b0, 3'd5);
      5'd15: m = mk(OPD_Q2, OPD_B3, 1'b0, 1'b0, 1'b0, 3'd5);
      5'd16: m = mk(OPD_Q3, OPD_B2, 1'b1, 1'b0, 1'b1, 3'd5);
      5'd17: m = mk(OPD_Q0, OPD_B2, 1'b0, 1'b1, 1'b0, 3'd6);
      5'd18: m = mk(OPD_Q1, OPD_B3, 1'b1, 1'b0, 1'b0, 3'd6);
      5'd19: m = mk(OPD_Q2, OPD_B0, 1'b0, 1'b0, 1'b0, 3'd6);
      5'd20: m = mk(OPD_Q3, OPD_B1, 1'b0, 1'b0, 1'b1, 3'd6);
      5'd21: m = mk(OPD_Q0, OPD_B3, 1'b0, 1'b1, 1'b0, 3'd7);
      5'd22: m = mk(OPD_Q1, OPD_B2, 1'b0, 1'b0, 1'b0, 3'd7);
      5'd23: m = mk(OPD_Q2, OPD_B1, 1'b1, 1'b0, 1'b0, 3'd7);
      5'd24: m = mk(OPD_Q3, OPD_B0, 1'b0, 1'b0, 1'b1, 3'd7);
      default: m = mk(OPD_S0, OPD_S0, 1'b0, 1'b1, 1'b1, 3'd0);
    endcase
    return m;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) r = 16'sh7fff;
    else if (v < -20'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/art_front.sv
// Front end: accepts input words, decodes the opcode and queues up to two entries.
// Depends on art_pkg.
`default_nettype none
module art_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_opcode,
  input  wire logic signed [13:0]  in_point_x,
  input  wire logic signed [13:0]  in_point_y,
  input  wire logic signed [15:0]  in_load_w,
  input  wire logic signed [15:0]  in_load_x,
  input  wire logic signed [15:0]  in_load_y,
  input  wire logic signed [15:0]  in_load_z,
  output logic                     q_valid,
  input  wire logic                q_pop,
  output art_pkg::item_t           q_item
);

  art_pkg::item_t ent_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  art_pkg::item_t it;
  logic           push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = ent_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    case (in_opcode)
      art_pkg::OP_BEGIN: it.cmd = art_pkg::CMD_BEGIN;
      art_pkg::OP_DRAG:  it.cmd = art_pkg::CMD_DRAG;
      art_pkg::OP_LOAD:  it.cmd = art_pkg::CMD_LOAD;
      default:           it.cmd = art_pkg::CMD_NOP;
    endcase
    it.px = in_point_x;
    it.py = in_point_y;
    it.lw = in_load_w;
    it.lx = in_load_x;
    it.ly = in_load_y;
    it.lz = in_load_z;
  end

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= it;
    end
  end

endmodule
`default_nettype wire

### hdl/art_isqrt.sv
// Integer square root, one result bit per cycle, floor result.
// Depends on art_pkg.
`default_nettype none
module art_isqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [59:0] val,
  output logic             done,
  output logic [29:0]      root
);

  logic [59:0] v_r, v_nxt, r_r, r_nxt, bit_r, bit_nxt, t;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt, done_r, done_nxt;

  assign done = done_r;
  assign root = r_r[29:0];
  assign t    = r_r + bit_r;

  always_comb begin
    v_nxt    = v_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt   = val;
      r_nxt   = '0;
      bit_nxt = 60'd1 << 58;
      cnt_nxt = 5'(art_pkg::ROOT_STEPS - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (v_r >= t) begin
        v_nxt = v_r - t;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule
`default_nettype wire

### hdl/art_back.sv
// Back end: sphere mapping, serial divide and root, shared multiplier for the
// quaternion updates, and the result word register. Depends on art_pkg, art_isqrt.
`default_nettype none
module art_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire art_pkg::cfg_t      cfg,
  input  wire logic               q_valid,
  output logic                    q_pop,
  input  wire art_pkg::item_t     q_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_rot_w,
  output logic signed [15:0]      out_rot_x,
  output logic signed [15:0]      out_rot_y,
  output logic signed [15:0]      out_rot_z
);

  art_pkg::state_e    st_r, st_nxt;
  art_pkg::item_t     item_r;
  art_pkg::mac_t      mac;
  logic               ovalid_r;
  logic [13:0]        ux_r, uy_r;
  logic               negx_r, negy_r, outside_r, dsel_r;
  logic [12:0]        rad_r;
  logic signed [31:0] prod_r;
  logic [29:0]        sum_r, sq;
  logic [29:0]        len_r;
  logic [46:0]        num_r, dsh_r;
  logic [15:0]        quo_r;
  logic [3:0]         cnt_r;
  logic [14:0]        mx_r, my_r, mz_r, mag;
  logic signed [15:0] s_r [3];
  logic signed [15:0] c_r [3];
  logic signed [15:0] qv_r [4];
  logic signed [15:0] base_r [4];
  logic signed [15:0] cur_r [4];
  logic [4:0]         t_r;
  logic signed [19:0] acc_r, acc_nxt;
  logic signed [17:0] term;
  logic signed [15:0] mul_a, mul_b, opa, opb;
  logic               ge, sq_start, sq_done;
  logic [59:0]        sq_val;
  logic [29:0]        sq_root;
  logic signed [14:0] dx, dy;
  logic [13:0]        u;

  art_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .val   (sq_val),
    .done  (sq_done),
    .root  (sq_root)
  );

  function automatic logic signed [15:0] opnd(input logic [3:0] idx,
      input logic signed [15:0] s0, input logic signed [15:0] s1,
      input logic signed [15:0] s2, input logic signed [15:0] c0,
      input logic signed [15:0] c1, input logic signed [15:0] c2,
      input logic signed [15:0] q0, input logic signed [15:0] q1,
      input logic signed [15:0] q2, input logic signed [15:0] q3,
      input logic signed [15:0] b0, input logic signed [15:0] b1,
      input logic signed [15:0] b2, input logic signed [15:0] b3);
    logic signed [15:0] r;
    case (idx)
      art_pkg::OPD_S0: r = s0;
      art_pkg::OPD_S1: r = s1;
      art_pkg::OPD_S2: r = s2;
      art_pkg::OPD_C0: r = c0;
      art_pkg::OPD_C1: r = c1;
      art_pkg::OPD_C2: r = c2;
      art_pkg::OPD_Q0: r = q0;
      art_pkg::OPD_Q1: r = q1;
      art_pkg::OPD_Q2: r = q2;
      art_pkg::OPD_Q3: r = q3;
      art_pkg::OPD_B0: r = b0;
      art_pkg::OPD_B1: r = b1;
      art_pkg::OPD_B2: r = b2;
      art_pkg::OPD_B3: r = b3;
      default:         r = '0;
    endcase
    return r;
  endfunction

  assign out_valid = ovalid_r;
  assign out_rot_w = cur_r[0];
  assign out_rot_x = cur_r[1];
  assign out_rot_y = cur_r[2];
  assign out_rot_z = cur_r[3];

  assign mac = art_pkg::mac_entry(t_r);
  assign opa = opnd(mac.a, s_r[0], s_r[1], s_r[2], c_r[0], c_r[1], c_r[2],
                    qv_r[0], qv_r[1], qv_r[2], qv_r[3],
                    base_r[0], base_r[1], base_r[2], base_r[3]);
  assign opb = opnd(mac.b, s_r[0], s_r[1], s_r[2], c_r[0], c_r[1], c_r[2],
                    qv_r[0], qv_r[1], qv_r[2], qv_r[3],
                    base_r[0], base_r[1], base_r[2], base_r[3]);

  assign dx   = $signed({item_r.px[13], item_r.px}) - $signed({2'b00, cfg.cx});
  assign dy   = $signed({item_r.py[13], item_r.py}) - $signed({2'b00, cfg.cy});
  assign u    = dsel_r ? uy_r : ux_r;
  assign ge   = (num_r >= dsh_r);
  assign sq   = sum_r + {1'b0, prod_r[28:0]};
  assign mag  = (quo_r > art_pkg::Q_ONE) ? art_pkg::Q_ONE[14:0] : quo_r[14:0];
  assign term = 18'(($signed(prod_r) + 32'sd8192) >>> art_pkg::FRAC_BITS);

  always_comb begin
    if (mac.first) acc_nxt = '0;
    else acc_nxt = acc_r;
    if (mac.neg) acc_nxt = acc_nxt - 20'(term);
    else acc_nxt = acc_nxt + 20'(term);
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      art_pkg::ST_IDLE: begin
        if (q_valid && !ovalid_r) begin
          case (q_item.cmd)
            art_pkg::CMD_BEGIN, art_pkg::CMD_DRAG: st_nxt = art_pkg::ST_MAP0;
            default:                               st_nxt = art_pkg::ST_DONE;
          endcase
        end
      end
      art_pkg::ST_MAP0: st_nxt = art_pkg::ST_SQX;
      art_pkg::ST_SQX:  st_nxt = art_pkg::ST_SQY;
      art_pkg::ST_SQY:  st_nxt = art_pkg::ST_SQR;
      art_pkg::ST_SQR:  st_nxt = art_pkg::ST_CMP;
      art_pkg::ST_CMP: begin
        if (sum_r > {4'b0, prod_r[25:0]}) st_nxt = art_pkg::ST_LEN;
        else st_nxt = art_pkg::ST_DIVS;
      end
      art_pkg::ST_LEN:  if (sq_done) st_nxt = art_pkg::ST_DIVS;
      art_pkg::ST_DIVS: st_nxt = art_pkg::ST_DIV;
      art_pkg::ST_DIV:  if (cnt_r == 4'd0) st_nxt = art_pkg::ST_DIVE;
      art_pkg::ST_DIVE: begin
        if (!dsel_r) st_nxt = art_pkg::ST_DIVS;
        else if (outside_r) st_nxt = art_pkg::ST_PTS;
        else st_nxt = art_pkg::ST_MZX;
      end
      art_pkg::ST_MZX:  st_nxt = art_pkg::ST_MZY;
      art_pkg::ST_MZY:  st_nxt = art_pkg::ST_MZS;
      art_pkg::ST_MZS: begin
        if (sq >= 30'd268435456) st_nxt = art_pkg::ST_PTS;
        else st_nxt = art_pkg::ST_ZSQ;
      end
      art_pkg::ST_ZSQ:  if (sq_done) st_nxt = art_pkg::ST_PTS;
      art_pkg::ST_PTS: begin
        if (item_r.cmd == art_pkg::CMD_DRAG) st_nxt = art_pkg::ST_MUL;
        else st_nxt = art_pkg::ST_DONE;
      end
      art_pkg::ST_MUL:  st_nxt = art_pkg::ST_ACC;
      art_pkg::ST_ACC: begin
        if (t_r == 5'(art_pkg::MAC_TERMS - 1)) st_nxt = art_pkg::ST_DONE;
        else st_nxt = art_pkg::ST_MUL;
      end
      art_pkg::ST_DONE: st_nxt = art_pkg::ST_IDLE;
      default:          st_nxt = art_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop    = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    sq_start = 1'b0;
    sq_val   = {sum_r, 30'b0};
    case (st_r)
      art_pkg::ST_IDLE: q_pop = q_valid && !ovalid_r;
      art_pkg::ST_SQX: begin
        mul_a = $signed({2'b00, ux_r});
        mul_b = $signed({2'b00, ux_r});
      end
      art_pkg::ST_SQY: begin
        mul_a = $signed({2'b00, uy_r});
        mul_b = $signed({2'b00, uy_r});
      end
      art_pkg::ST_SQR: begin
        mul_a = $signed({3'b000, rad_r});
        mul_b = $signed({3'b000, rad_r});
      end
      art_pkg::ST_CMP: sq_start = (sum_r > {4'b0, prod_r[25:0]});
      art_pkg::ST_MZX: begin
        mul_a = $signed({1'b0, mx_r});
        mul_b = $signed({1'b0, mx_r});
      end
      art_pkg::ST_MZY: begin
        mul_a = $signed({1'b0, my_r});
        mul_b = $signed({1'b0, my_r});
      end
      art_pkg::ST_MZS: begin
        sq_start = (sq < 30'd268435456);
        sq_val   = {30'b0, 30'd268435456 - sq};
      end
      art_pkg::ST_MUL: begin
        mul_a = opa;
        mul_b = opb;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= art_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        cur_r[i]  <= (i == 0) ? $signed(art_pkg::Q_ONE) : 16'sd0;
        base_r[i] <= (i == 0) ? $signed(art_pkg::Q_ONE) : 16'sd0;
      end
      for (int i = 0; i < 3; i++) begin
        s_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (st_r == art_pkg::ST_DONE) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
      case (st_r)
        art_pkg::ST_IDLE: begin
          if (q_pop) begin
            case (q_item.cmd)
              art_pkg::CMD_BEGIN: begin
                for (int i = 0; i < 4; i++) base_r[i] <= cur_r[i];
              end
              art_pkg::CMD_LOAD: begin
                cur_r[0] <= q_item.lw;
                cur_r[1] <= q_item.lx;
                cur_r[2] <= q_item.ly;
                cur_r[3] <= q_item.lz;
              end
              default: ;
            endcase
          end
        end
        art_pkg::ST_PTS: begin
          if (item_r.cmd == art_pkg::CMD_BEGIN) begin
            s_r[0] <= negx_r ? -$signed({1'b0, mx_r}) : $signed({1'b0, mx_r});
            s_r[1] <= negy_r ? -$signed({1'b0, my_r}) : $signed({1'b0, my_r});
            s_r[2] <= $signed({1'b0, mz_r});
          end
        end
        art_pkg::ST_ACC: begin
          if (mac.last && mac.dest[2]) cur_r[mac.dest[1:0]] <= art_pkg::sat16(acc_nxt);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (st_r)
      art_pkg::ST_IDLE: if (q_pop) item_r <= q_item;
      art_pkg::ST_MAP0: begin
        ux_r   <= dx[14] ? 14'(-dx) : dx[13:0];
        uy_r   <= dy[14] ? 14'(-dy) : dy[13:0];
        negx_r <= dx[14];
        negy_r <= dy[14];
        rad_r  <= (cfg.rad == 13'd0) ? 13'd1 : cfg.rad;
        dsel_r <= 1'b0;
      end
      art_pkg::ST_SQY: sum_r <= {1'b0, prod_r[28:0]};
      art_pkg::ST_SQR: sum_r <= sum_r + {1'b0, prod_r[28:0]};
      art_pkg::ST_CMP: begin
        outside_r <= (sum_r > {4'b0, prod_r[25:0]});
        mz_r      <= '0;
      end
      art_pkg::ST_LEN: if (sq_done) len_r <= sq_root;
      art_pkg::ST_DIVS: begin
        if (outside_r) begin
          num_r <= {3'b0, u, 30'b0} + {17'b0, len_r};
          dsh_r <= {1'b0, len_r, 16'b0};
        end else begin
          num_r <= {18'b0, u, 15'b0} + {34'b0, rad_r};
          dsh_r <= {18'b0, rad_r, 16'b0};
        end
        quo_r <= '0;
        cnt_r <= 4'd15;
      end
      art_pkg::ST_DIV: begin
        quo_r <= {quo_r[14:0], ge};
        if (ge) num_r <= num_r - dsh_r;
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 4'd1;
      end
      art_pkg::ST_DIVE: begin
        if (dsel_r) my_r <= mag;
        else mx_r <= mag;
        dsel_r <= 1'b1;
      end
      art_pkg::ST_MZY: sum_r <= {1'b0, prod_r[28:0]};
      art_pkg::ST_ZSQ: if (sq_done) mz_r <= sq_root[14:0];
      art_pkg::ST_PTS: begin
        c_r[0] <= negx_r ? -$signed({1'b0, mx_r}) : $signed({1'b0, mx_r});
        c_r[1] <= negy_r ? -$signed({1'b0, my_r}) : $signed({1'b0, my_r});
        c_r[2] <= $signed({1'b0, mz_r});
        t_r    <= '0;
      end
      art_pkg::ST_ACC: begin
        acc_r <= acc_nxt;
        t_r   <= t_r + 5'd1;
        if (mac.last && !mac.dest[2]) qv_r[mac.dest[1:0]] <= art_pkg::sat16(acc_nxt);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hdl/arcball_rotation_tracker.sv
// Arcball rotation tracker top level: config registers, front queue, back engine.
// Depends on art_pkg, art_front, art_back.
// Load or unused opcode go straight to the result word. Begin and drag map the point onto
// the sphere by two serial divides and, where needed, a serial root; drag then runs 25
// multiply-accumulate steps on one shared multiplier. The back end starts a new word
// only after the last result is taken; a two-word queue takes input meanwhile.
// Synchronous active-low reset: identity rotation, zero start point, radius 256.
`default_nettype none
module arcball_rotation_tracker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [12:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic signed [13:0] in_point_x,
  input  wire logic signed [13:0] in_point_y,
  input  wire logic signed [15:0] in_load_w,
  input  wire logic signed [15:0] in_load_x,
  input  wire logic signed [15:0] in_load_y,
  input  wire logic signed [15:0] in_load_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_rot_w,
  output logic signed [15:0]      out_rot_x,
  output logic signed [15:0]      out_rot_y,
  output logic signed [15:0]      out_rot_z
);

  art_pkg::cfg_t  cfg_r;
  art_pkg::item_t q_item;
  logic           q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cx  <= '0;
      cfg_r.cy  <= '0;
      cfg_r.rad <= 13'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        art_pkg::REG_CENTER_X: cfg_r.cx  <= cfg_wdata;
        art_pkg::REG_CENTER_Y: cfg_r.cy  <= cfg_wdata;
        art_pkg::REG_RADIUS:   cfg_r.rad <= cfg_wdata;
        default: ;
      endcase
    end
  end

  art_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_opcode  (in_opcode),
    .in_point_x (in_point_x),
    .in_point_y (in_point_y),
    .in_load_w  (in_load_w),
    .in_load_x  (in_load_x),
    .in_load_y  (in_load_y),
    .in_load_z  (in_load_z),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item)
  );

  art_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rot_w (out_rot_w),
    .out_rot_x (out_rot_x),
    .out_rot_y (out_rot_y),
    .out_rot_z (out_rot_z)
  );

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for arcball_rotation_tracker: directed table, then random
// command sequences, each result checked against an in-bench quaternion predictor.
// Depends on art_pkg and the arcball_rotation_tracker RTL.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic [1:0]         op;
    logic signed [13:0] px, py;
    logic signed [15:0] lw, lx, ly, lz;
    bit                 known;
    logic signed [15:0] ew, ex, ey, ez;
  } row_t;

  typedef struct {
    logic signed [15:0] w, x, y, z;
  } rot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = art_pkg::REG_CENTER_X;
  logic [12:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = art_pkg::OP_BEGIN;
  logic signed [13:0] in_point_x = '0, in_point_y = '0;
  logic signed [15:0] in_load_w = '0, in_load_x = '0, in_load_y = '0, in_load_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_rot_w, out_rot_x, out_rot_y, out_rot_z;

  longint m_cx, m_cy, m_rad;
  longint cur_q[4], base_q[4], start_p[3];
  rot_t rot_fifo[$];
  bit failed = 0;
  bit rx_burst_off = 0;
  longint cycles = 0;
  row_t dir_rows[$];

  arcball_rotation_tracker uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint n;
    n = a * b + (longint'(1) <<< (art_pkg::FRAC_BITS - 1));
    if (n >= 0) return n >>> art_pkg::FRAC_BITS;
    return -((-n + (longint'(1) <<< art_pkg::FRAC_BITS) - 1) >>> art_pkg::FRAC_BITS);
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint rdiv(longint unsigned n, longint unsigned d);
    return longint'((2 * n + d) / (2 * d));
  endfunction

  task automatic sphere_point(input logic signed [13:0] px, input logic signed [13:0] py,
                              output longint p[3]);
    longint dx, dy, ux, uy, r, s, len, mx, my, mz, one, sq;
    one = longint'(1) <<< art_pkg::FRAC_BITS;
    dx = longint'(px) - m_cx;
    dy = longint'(py) - m_cy;
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    r = m_rad != 0 ? m_rad : 1;
    s = ux * ux + uy * uy;
    if (s > r * r) begin
      len = int_root(s <<< (2 * art_pkg::EXTRA_BITS));
      mx = rdiv(ux <<< (art_pkg::FRAC_BITS + art_pkg::EXTRA_BITS), len);
      my = rdiv(uy <<< (art_pkg::FRAC_BITS + art_pkg::EXTRA_BITS), len);
      if (mx > one) mx = one;
      if (my > one) my = one;
      mz = 0;
    end else begin
      mx = rdiv(ux <<< art_pkg::FRAC_BITS, r);
      my = rdiv(uy <<< art_pkg::FRAC_BITS, r);
      sq = mx * mx + my * my;
      mz = sq >= one * one ? 0 : int_root(one * one - sq);
    end
    p[0] = dx < 0 ? -mx : mx;
    p[1] = dy < 0 ? -my : my;
    p[2] = mz;
  endtask

  task automatic predict_rotation(input row_t it, output rot_t res);
    longint c[3], q[4], s[3], b[4];
    case (it.op)
      art_pkg::OP_BEGIN: begin
        base_q = cur_q;
        sphere_point(it.px, it.py, start_p);
      end
      art_pkg::OP_DRAG: begin
        sphere_point(it.px, it.py, c);
        s = start_p;
        b = base_q;
        q[0] = clamp(qmul(s[0], c[0]) + qmul(s[1], c[1]) + qmul(s[2], c[2]), art_pkg::Q_BITS);
        q[1] = clamp(qmul(s[1], c[2]) - qmul(s[2], c[1]), art_pkg::Q_BITS);
        q[2] = clamp(qmul(s[2], c[0]) - qmul(s[0], c[2]), art_pkg::Q_BITS);
        q[3] = clamp(qmul(s[0], c[1]) - qmul(s[1], c[0]), art_pkg::Q_BITS);
        cur_q[0] = clamp(qmul(q[0], b[0]) - qmul(q[1], b[1]) - qmul(q[2], b[2])
                         - qmul(q[3], b[3]), art_pkg::Q_BITS);
        cur_q[1] = clamp(qmul(q[0], b[1]) + qmul(q[1], b[0]) + qmul(q[2], b[3])
                         - qmul(q[3], b[2]), art_pkg::Q_BITS);
        cur_q[2] = clamp(qmul(q[0], b[2]) - qmul(q[1], b[3]) + qmul(q[2], b[0])
                         + qmul(q[3], b[1]), art_pkg::Q_BITS);
        cur_q[3] = clamp(qmul(q[0], b[3]) + qmul(q[1], b[2]) - qmul(q[2], b[1])
                         + qmul(q[3], b[0]), art_pkg::Q_BITS);
      end
      art_pkg::OP_LOAD: begin
        cur_q[0] = clamp(it.lw, art_pkg::Q_BITS);
        cur_q[1] = clamp(it.lx, art_pkg::Q_BITS);
        cur_q[2] = clamp(it.ly, art_pkg::Q_BITS);
        cur_q[3] = clamp(it.lz, art_pkg::Q_BITS);
      end
      default: ;
    endcase
    res.w = clamp(cur_q[0], 16);
    res.x = clamp(cur_q[1], 16);
    res.y = clamp(cur_q[2], 16);
    res.z = clamp(cur_q[3], 16);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      art_pkg::REG_CENTER_X: m_cx = val;
      art_pkg::REG_CENTER_Y: m_cy = val;
      default: m_rad = val;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rot_fifo.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic send_word(input row_t it, input bit gaps);
    rot_t res;
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_opcode <= it.op;
    in_point_x <= it.px;
    in_point_y <= it.py;
    in_load_w <= it.lw;
    in_load_x <= it.lx;
    in_load_y <= it.ly;
    in_load_z <= it.lz;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_rotation(it, res);
    if (it.known && (res.w !== it.ew || res.x !== it.ex || res.y !== it.ey ||
                     res.z !== it.ez)) begin
      $display("%0t table expects %0d %0d %0d %0d, predictor %0d %0d %0d %0d", $time,
               it.ew, it.ex, it.ey, it.ez, res.w, res.x, res.y, res.z);
      failed = 1;
    end
    rot_fifo.push_back(res);
  endtask

  always @(posedge clk) begin
    rot_t e;
    if (rst_n && out_valid && out_ready) begin
      if (rot_fifo.size() == 0) begin
        $display("%0t unexpected word %0d %0d %0d %0d", $time,
                 out_rot_w, out_rot_x, out_rot_y, out_rot_z);
        failed = 1;
      end else begin
        e = rot_fifo.pop_front();
        if (out_rot_w !== e.w || out_rot_x !== e.x || out_rot_y !== e.y ||
            out_rot_z !== e.z) begin
          $display("%0t expected %0d %0d %0d %0d, got %0d %0d %0d %0d", $time,
                   e.w, e.x, e.y, e.z, out_rot_w, out_rot_x, out_rot_y, out_rot_z);
          failed = 1;
        end
      end
    end
  end

  initial begin : rx_side
    int n;
    forever begin
      if (rx_burst_off || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 8);
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic row_t mk_row(logic [1:0] op, logic signed [13:0] px,
                                  logic signed [13:0] py, logic signed [15:0] lw,
                                  logic signed [15:0] lx, logic signed [15:0] ly,
                                  logic signed [15:0] lz, bit known,
                                  logic signed [15:0] ew, logic signed [15:0] ex,
                                  logic signed [15:0] ey, logic signed [15:0] ez);
    row_t r;
    r.op = op; r.px = px; r.py = py; r.lw = lw; r.lx = lx; r.ly = ly; r.lz = lz;
    r.known = known; r.ew = ew; r.ex = ex; r.ey = ey; r.ez = ez;
    return r;
  endfunction

  initial begin : tx_side
    row_t it;
    int k, g;
    logic [12:0] rad;
    m_cx = 0; m_cy = 0; m_rad = 256;
    cur_q = '{16384, 0, 0, 0};
    base_q = '{16384, 0, 0, 0};
    start_p = '{0, 0, 0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset identity, drag with no begin (zero quaternion), loads at extremes
    dir_rows.push_back(mk_row(art_pkg::OP_NONE, 0, 0, 0, 0, 0, 0, 1, 16384, 0, 0, 0));
    dir_rows.push_back(mk_row(art_pkg::OP_DRAG, 100, -50, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(art_pkg::OP_LOAD, 0, 0, 16'sh7fff, 16'sh8000, 0, -1, 1,
                              16'sh7fff, 16'sh8000, 0, -1));
    dir_rows.push_back(mk_row(art_pkg::OP_LOAD, 0, 0, 16384, 0, 0, 0, 1, 16384, 0, 0, 0));
    dir_rows.push_back(mk_row(art_pkg::OP_BEGIN, 0, 0, 0, 0, 0, 0, 1, 16384, 0, 0, 0));
    dir_rows.push_back(mk_row(art_pkg::OP_DRAG, 0, 0, 0, 0, 0, 0, 1, 16384, 0, 0, 0));
    dir_rows.push_back(mk_row(art_pkg::OP_DRAG, 256, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(art_pkg::OP_DRAG, 181, 181, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(art_pkg::OP_DRAG, 14'sh1fff, 14'sh2000,
                              0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(art_pkg::OP_BEGIN, -256, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(art_pkg::OP_DRAG, 0, 256, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(art_pkg::OP_DRAG, 14'sh2000, 14'sh1fff,
                              0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(art_pkg::OP_NONE, -1, -1, 16'sh7fff, 0, 0, 0, 0, 0, 0, 0, 0));
    foreach (dir_rows[i]) send_word(dir_rows[i], 0);
    drain();

    write_reg(art_pkg::REG_RADIUS, 13'd0);
    send_word(mk_row(art_pkg::OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_word(mk_row(art_pkg::OP_DRAG, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    send_word(mk_row(art_pkg::OP_DRAG, 14'sh1fff, 14'sh1fff, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin write_reg(art_pkg::REG_CENTER_X, 13'h1fff);
                  write_reg(art_pkg::REG_CENTER_Y, 13'h1fff);
                  write_reg(art_pkg::REG_RADIUS, 13'h1fff); end
        1: begin write_reg(art_pkg::REG_CENTER_X, 0); write_reg(art_pkg::REG_CENTER_Y, 0);
                  write_reg(art_pkg::REG_RADIUS, 1); end
        default: begin
          write_reg(art_pkg::REG_CENTER_X, $urandom_range(0, 8191));
          write_reg(art_pkg::REG_CENTER_Y, $urandom_range(0, 8191));
          rad = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 600);
          write_reg(art_pkg::REG_RADIUS, rad);
        end
      endcase
      if (ph == 6) rx_burst_off = 1;
      for (k = 0; k < 200; k++) begin
        it = mk_row(art_pkg::OP_DRAG, 0, 0, $urandom, $urandom, $urandom, $urandom,
                    0, 0, 0, 0, 0);
        g = $urandom_range(0, 19);
        if (g == 0) it.op = art_pkg::OP_LOAD;
        else if (g == 1) it.op = art_pkg::OP_NONE;
        else if (g < 5) it.op = art_pkg::OP_BEGIN;
        if ($urandom_range(0, 4) == 0) begin
          it.px = $urandom;
          it.py = $urandom;
        end else begin
          it.px = m_cx + $signed($urandom_range(0, 2 * (m_rad + 2))) - (m_rad + 2);
          it.py = m_cy + $signed($urandom_range(0, 2 * (m_rad + 2))) - (m_rad + 2);
        end
        if (g == 0 && $urandom_range(0, 1)) begin
          it.lw = $signed($urandom_range(0, 32767)) - 16384;
          it.lx = $signed($urandom_range(0, 32767)) - 16384;
          it.ly = $signed($urandom_range(0, 32767)) - 16384;
          it.lz = $signed($urandom_range(0, 32767)) - 16384;
        end
        send_word(it, ph != 6);
        if (ph == 3 && k == 100) begin
          in_valid <= 1'b0;
          while (rot_fifo.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (!failed && rot_fifo.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
